// ===== rtl/core/bba_pkg.sv =====
package bba_pkg;

    localparam int BLOCK_W  = 10;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 11;
    localparam int WORD_W   = 32;
    localparam int BIT_W    = 5;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd1024;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DOUBLE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd3;

    localparam logic REG_TOTAL_BLOCKS = 1'b0;

    typedef enum logic [1:0]
    {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_FREE
    } state_t;

    typedef struct packed
    {
        logic             found;
        logic [BIT_W-1:0] pos;
    } scan_result_t;

endpackage

// ===== rtl/core/bba_ram.sv =====
module bba_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/bba_word_scan.sv =====
module bba_word_scan #(
    parameter int XW = 19
) (
    input  logic [bba_pkg::WORD_W-1:0] word,
    input  logic [XW-1:0]              base,
    input  logic [XW-1:0]              limit,
    output bba_pkg::scan_result_t      result
);

    import bba_pkg::*;

    logic [WORD_W-1:0] avail;

    always_comb
    begin
        for (int j = 0; j < WORD_W; j++)
        begin
            avail[j] = !word[j] && ((base + XW'(j)) < limit);
        end
    end

    always_comb
    begin
        result.found = |avail;
        result.pos   = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (avail[j])
            begin
                result.pos = BIT_W'(j);
            end
        end
    end

endmodule

// ===== rtl/core/block_bitmap_allocator_top.sv =====
// First-fit block allocator over a bitmap held in a single-port-write RAM of 32-bit words.
// After reset the block runs a clearing pass over all bitmap words, with busy high, before
// it accepts its first transaction. An allocate reads one bitmap word per cycle from block 0
// upwards, with busy high, up to the first free block; it reads at most ceil(limit/32) words,
// or one word when the limit is zero, the limit being the smaller of total_blocks and MAX_BLOCKS.
// The result appears with done for exactly one cycle, the cycle in which busy falls; the
// receiver cannot stall it and must take it then.
module block_bitmap_allocator_top #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic [bba_pkg::BLOCK_W-1:0]   block_number,
    output logic                          done,
    output logic [bba_pkg::BLOCK_W-1:0]   granted_block,
    output logic [bba_pkg::STATUS_W-1:0]  status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    import bba_pkg::*;

    localparam int WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LW    = $clog2(MAX_BLOCKS + 1);
    localparam int CW    = (LW > TOTAL_W) ? LW : TOTAL_W;
    localparam int XW    = CW + 2;
    localparam logic [AW-1:0] LAST_ADDR = AW'(WORDS - 1);

    state_t               state_reg, state_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [BLOCK_W-1:0]   num_reg, num_next;
    logic                 done_reg, done_next;
    logic [BLOCK_W-1:0]   granted_reg, granted_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [TOTAL_W-1:0]   total_blocks_reg, total_blocks_next;

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [WORD_W-1:0]    rd_data;
    logic                 wr_en;
    logic [WORD_W-1:0]    wr_data;

    logic [XW-1:0]        total_ext;
    logic [XW-1:0]        max_ext;
    logic [XW-1:0]        limit;
    logic [XW-1:0]        base;
    logic [AW:0]          addr_inc;
    logic [XW-1:0]        next_base;
    logic [AW-1:0]        free_addr;
    logic [WORD_W-1:0]    alloc_mask;
    logic [WORD_W-1:0]    free_mask;
    logic                 cfg_write;
    scan_result_t         scan;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_TOTAL_BLOCKS) ? 32'(total_blocks_reg) : 32'd0;

    always_comb
    begin
        total_blocks_next = total_blocks_reg;
        if (cfg_write && (paddr[2] == REG_TOTAL_BLOCKS))
        begin
            total_blocks_next = pwdata[TOTAL_W-1:0];
        end
    end

    assign total_ext = XW'(total_blocks_reg);
    assign max_ext   = XW'(MAX_BLOCKS);
    assign limit     = (total_ext < max_ext) ? total_ext : max_ext;
    assign base      = XW'({addr_reg, {BIT_W{1'b0}}});
    assign addr_inc  = {1'b0, addr_reg} + (AW + 1)'(1);
    assign next_base = XW'({addr_inc, {BIT_W{1'b0}}});
    assign free_addr = AW'(block_number >> BIT_W);
    assign alloc_mask = WORD_W'(1) << scan.pos;
    assign free_mask  = WORD_W'(1) << num_reg[BIT_W-1:0];

    bba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS),
        .ADDR_W(AW)
    ) u_map_ram (
        .clk  (clk),
        .we   (wr_en),
        .waddr(addr_reg),
        .wdata(wr_data),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    bba_word_scan #(
        .XW(XW)
    ) u_word_scan (
        .word  (rd_data),
        .base  (base),
        .limit (limit),
        .result(scan)
    );

    always_comb
    begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        num_next     = num_reg;
        done_next    = 1'b0;
        granted_next = granted_reg;
        status_next  = status_reg;
        rd_en        = 1'b0;
        rd_addr      = addr_reg;
        wr_en        = 1'b0;
        wr_data      = rd_data;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en     = 1'b1;
                wr_data   = '0;
                addr_next = addr_inc[AW-1:0];
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    num_next = block_number;
                    rd_en    = 1'b1;
                    if (op == OP_ALLOC)
                    begin
                        addr_next  = '0;
                        rd_addr    = '0;
                        state_next = S_ALLOC;
                    end
                    else
                    begin
                        addr_next  = free_addr;
                        rd_addr    = free_addr;
                        state_next = S_FREE;
                    end
                end
            end
            S_ALLOC:
            begin
                if (scan.found)
                begin
                    wr_en        = 1'b1;
                    wr_data      = rd_data | alloc_mask;
                    done_next    = 1'b1;
                    granted_next = BLOCK_W'({addr_reg, scan.pos});
                    status_next  = ST_OK;
                    state_next   = S_IDLE;
                end
                else if (next_base < limit)
                begin
                    addr_next = addr_inc[AW-1:0];
                    rd_addr   = addr_inc[AW-1:0];
                    rd_en     = 1'b1;
                end
                else
                begin
                    done_next    = 1'b1;
                    granted_next = '0;
                    status_next  = ST_FULL;
                    state_next   = S_IDLE;
                end
            end
            S_FREE:
            begin
                done_next    = 1'b1;
                granted_next = '0;
                state_next   = S_IDLE;
                if (XW'(num_reg) >= limit)
                begin
                    status_next = ST_RANGE;
                end
                else if (!rd_data[num_reg[BIT_W-1:0]])
                begin
                    status_next = ST_DOUBLE;
                end
                else
                begin
                    wr_en       = 1'b1;
                    wr_data     = rd_data & ~free_mask;
                    status_next = ST_OK;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            addr_reg         <= '0;
            done_reg         <= 1'b0;
            total_blocks_reg <= TOTAL_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            addr_reg         <= addr_next;
            done_reg         <= done_next;
            total_blocks_reg <= total_blocks_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg     <= num_next;
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign granted_block = granted_reg;
    assign status        = status_reg;

    a_done_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe outside idle state");

    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg != ST_OK)) |-> (granted_reg == '0))
        else $error("non-zero block number on a failed transaction");

    a_free_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FREE) |=> done_reg)
        else $error("free transaction did not complete in one check cycle");

    a_full_from_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ST_FULL)) |-> ($past(state_reg) == S_ALLOC))
        else $error("full status not produced by an allocation");

endmodule

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    localparam int MAX_BLOCKS = 1024;
    localparam int STALL_LIMIT = 2000;
    localparam logic [2:0] ADDR_TOTAL_BLOCKS = {REG_TOTAL_BLOCKS, 2'b00};

    typedef struct
    {
        logic [BLOCK_W-1:0]  granted;
        logic [STATUS_W-1:0] status;
    } grant_t;

    class bitmap_ledger;
        bit [MAX_BLOCKS-1:0] used_map;
        logic [TOTAL_W-1:0]  total_blocks;
        grant_t              expected_grants[$];
        int                  errors;

        function new();
            used_map     = '0;
            total_blocks = TOTAL_RESET;
            errors       = 0;
        endfunction

        function int block_limit();
            return (total_blocks > MAX_BLOCKS) ? MAX_BLOCKS : int'(total_blocks);
        endfunction

        function void predict_grant(logic req_op, logic [BLOCK_W-1:0] num);
            grant_t g;
            int     limit;
            limit     = block_limit();
            g.granted = '0;
            g.status  = ST_FULL;
            if (req_op == OP_ALLOC)
            begin
                for (int i = 0; i < limit; i++)
                begin
                    if (!used_map[i])
                    begin
                        used_map[i] = 1'b1;
                        g.granted   = BLOCK_W'(i);
                        g.status    = ST_OK;
                        break;
                    end
                end
            end
            else if (int'(num) >= limit)
            begin
                g.status = ST_RANGE;
            end
            else if (!used_map[num])
            begin
                g.status = ST_DOUBLE;
            end
            else
            begin
                used_map[num] = 1'b0;
                g.status      = ST_OK;
            end
            expected_grants.push_back(g);
        endfunction

        function void check_grant(logic [BLOCK_W-1:0] granted, logic [STATUS_W-1:0] stat);
            grant_t g;
            if (expected_grants.size() == 0)
            begin
                $display("%0t: unexpected result granted_block=%0d status=%0d",
                         $time, granted, stat);
                errors++;
                return;
            end
            g = expected_grants.pop_front();
            if (granted !== g.granted)
            begin
                $display("%0t: granted_block expected %0d actual %0d",
                         $time, g.granted, granted);
                errors++;
            end
            if (stat !== g.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, g.status, stat);
                errors++;
            end
        endfunction

        function int pending();
            return expected_grants.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                op;
    logic [BLOCK_W-1:0]  block_number;
    logic                done;
    logic [BLOCK_W-1:0]  granted_block;
    logic [STATUS_W-1:0] status;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    bitmap_ledger ledger = new();
    int           stall_cycles = 0;
    int           idle_pct = 0;

    block_bitmap_allocator_top #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .op            (op),
        .block_number  (block_number),
        .done          (done),
        .granted_block (granted_block),
        .status        (status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The result of the previous transaction is checked before the new one is predicted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                ledger.check_grant(granted_block, status);
            if (start && !busy)
                ledger.predict_grant(op, block_number);
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic request(logic req_op, logic [BLOCK_W-1:0] num);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start        <= 1'b1;
        op           <= req_op;
        block_number <= num;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (ledger.pending() != 0 || busy)
            @(posedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic set_total_blocks(logic [TOTAL_W-1:0] value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TOTAL_BLOCKS;
        pwdata  <= {{(32-TOTAL_W){1'b0}}, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        ledger.total_blocks = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {{(32-TOTAL_W){1'b0}}, value})
        begin
            $display("%0t: total_blocks read expected %0d actual %0d", $time, value, prdata);
            ledger.errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_request();
        int limit;
        int top;
        limit = ledger.block_limit();
        top   = (limit > MAX_BLOCKS - 1) ? MAX_BLOCKS - 1 : limit;
        if ($urandom_range(99) < 55)
            request(OP_ALLOC, BLOCK_W'($urandom_range(0, MAX_BLOCKS - 1)));
        else if ($urandom_range(99) < 50)
            request(OP_FREE, BLOCK_W'($urandom_range(0, (top > 48) ? 48 : top)));
        else if ($urandom_range(99) < 60)
            request(OP_FREE, BLOCK_W'($urandom_range(0, top)));
        else
            request(OP_FREE, BLOCK_W'($urandom_range(0, MAX_BLOCKS - 1)));
    endtask

    initial
    begin
        logic [TOTAL_W-1:0] totals[10];
        int                 phase_idle[3];
        totals       = '{11'd1, 11'd8, 11'd32, 11'd33, 11'd64, 11'd100,
                         11'd1024, 11'd2047, 11'd0, 11'd1000};
        phase_idle   = '{24, 82, 0};
        rst_n        = 1'b0;
        start        = 1'b0;
        op           = OP_ALLOC;
        block_number = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        idle_pct = 24;
        request(OP_FREE, 10'd0);
        request(OP_FREE, 10'd1023);
        request(OP_ALLOC, 10'd1023);
        request(OP_ALLOC, 10'd0);
        request(OP_ALLOC, 10'h2AA);
        request(OP_FREE, 10'd1);
        request(OP_FREE, 10'd1);
        request(OP_ALLOC, 10'h155);
        set_total_blocks(11'd2);
        request(OP_ALLOC, 10'd0);
        request(OP_FREE, 10'd2);
        request(OP_FREE, 10'd1023);
        request(OP_FREE, 10'd1);
        request(OP_ALLOC, 10'd0);
        set_total_blocks(11'd0);
        request(OP_ALLOC, 10'd0);
        request(OP_FREE, 10'd0);
        set_total_blocks(11'd2047);
        request(OP_FREE, 10'd1023);
        request(OP_ALLOC, 10'd0);
        request(OP_FREE, 10'd3);
        set_total_blocks(11'd1);
        request(OP_ALLOC, 10'd0);
        request(OP_FREE, 10'd0);
        request(OP_ALLOC, 10'd0);
        set_total_blocks(TOTAL_RESET);

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = phase_idle[phase];
            for (int seg = 0; seg < 5; seg++)
            begin
                if (phase == 2 && seg == 4)
                    set_total_blocks(TOTAL_W'($urandom_range(1, 2047)));
                else
                    set_total_blocks(totals[(phase * 5 + seg) % 10]);
                repeat (50) random_request();
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (ledger.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/bba_pkg.sv
rtl/core/bba_ram.sv
rtl/core/bba_word_scan.sv
rtl/core/block_bitmap_allocator_top.sv
bench/tb.sv
